[rtl/quorum_transaction_tracker_top_defines.svh]
// ----------------------------------------------------------------------------
// Quorum transaction tracker assertion macros
// Concurrent assertion wrappers used by the tracker sequencer; they compile away
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef QUORUM_TRANSACTION_TRACKER_TOP_DEFINES_SVH
`define QUORUM_TRANSACTION_TRACKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property, sampled on the rising clock edge, off while reset is low.
`define QTT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication from a trigger to a consequence.
`define QTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define QTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define QTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/qtt_pkg.sv]
// ----------------------------------------------------------------------------
// Quorum transaction tracker package
// Shared constants, codes and record types of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package qtt_pkg;

	localparam int QTT_TABLE_DEPTH = 16;

	// Input item kinds.
	localparam logic [1:0] FUNC_OPEN  = 2'd0;
	localparam logic [1:0] FUNC_REPLY = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	// Result event codes.
	localparam logic [1:0] EV_SUCCESS = 2'd0;
	localparam logic [1:0] EV_FAILURE = 2'd1;
	localparam logic [1:0] EV_EXPIRED = 2'd2;
	localparam logic [1:0] EV_FULL    = 2'd3;

	// Register indexes (paddr[2]) and reset values.
	localparam logic REG_EXPIRE = 1'b0;
	localparam logic REG_QUORUM = 1'b1;
	localparam logic [15:0] EXPIRE_RESET = 16'd8;
	localparam logic [1:0]  QUORUM_RESET = 2'd2;

	localparam logic [1:0] REPLIES_MAX = 2'd3;

	typedef struct packed {
		logic [30:0] id;
		logic [1:0]  op;
		logic [31:0] tstamp;
		logic [1:0]  replies;
	} entry_t;

	typedef struct packed {
		logic [15:0] expire_ticks;
		logic [1:0]  quorum_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [30:0] trans_id;
		logic [1:0]  op_kind;
	} result_t;

endpackage

`default_nettype wire

[rtl/qtt_if.sv]
// ----------------------------------------------------------------------------
// Quorum transaction tracker channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [30:0] trans_id;
	logic [1:0]  op_kind;
	logic [31:0] now;
	logic        reply_success;

	modport source (output valid, func, trans_id, op_kind, now, reply_success, input ready);
	modport sink (input valid, func, trans_id, op_kind, now, reply_success, output ready);
endinterface

interface qtt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [30:0] trans_id_out;
	logic [1:0]  op_kind_out;
	logic        last;

	modport source (output valid, event_res, trans_id_out, op_kind_out, last, input ready);
	modport sink (input valid, event_res, trans_id_out, op_kind_out, last, output ready);
endinterface

`default_nettype wire

[rtl/qtt_cfg.sv]
// ----------------------------------------------------------------------------
// Quorum transaction tracker register file
// APB-style access to the expiry limit and the quorum count.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_cfg
	import qtt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expire_ticks <= EXPIRE_RESET;
			cfg_q.quorum_count <= QUORUM_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_EXPIRE: cfg_q.expire_ticks <= pwdata[15:0];
				REG_QUORUM: cfg_q.quorum_count <= pwdata[1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EXPIRE: prdata = {16'b0, cfg_q.expire_ticks};
			REG_QUORUM: prdata = {30'b0, cfg_q.quorum_count};
		endcase
	end

endmodule

`default_nettype wire

[rtl/qtt_mem.sv]
// ----------------------------------------------------------------------------
// Quorum transaction tracker entry memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_mem
	import qtt_pkg::*;
#(
	parameter int DEPTH = QTT_TABLE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/qtt_ctrl.sv]
// ----------------------------------------------------------------------------
// Quorum transaction tracker sequencer
// Scans the entry memory once per open, reply or tick item, applies the update and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quorum_transaction_tracker_top_defines.svh"

module qtt_ctrl
	import qtt_pkg::*;
#(
	parameter int DEPTH = QTT_TABLE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
)
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	qtt_in_if.sink             in_ch,
	qtt_out_if.source          out_ch,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output entry_t             mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  wire entry_t        mem_rdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN, ST_FLUSH} state_t;

	state_t         state_q;
	logic [1:0]     func_q;
	logic [30:0]    id_q;
	logic [1:0]     op_kind_q;
	logic [31:0]    now_q;
	logic           ok_q;
	logic [CW-1:0]  iss_q;
	logic [AW-1:0]  d_idx_s1;
	logic           d_vld_s1;
	logic [DEPTH-1:0] valid_q;
	logic           found_q;
	logic [AW-1:0]  match_q;
	entry_t         match_ent_q;
	logic           free_found_q;
	logic [AW-1:0]  free_q;
	logic           pend_v_q;
	result_t        pend_q;
	logic           out_v_q;
	result_t        out_q;
	logic           out_last_q;

	logic           iss_done;
	logic           ent_valid;
	logic           id_hit;
	logic [32:0]    limit;
	logic           expired;
	logic           out_busy;
	logic           stall;
	logic           adv;
	logic           out_load;
	logic           out_load_last;
	logic [1:0]     new_rep;
	logic           quorum_hit;
	logic           is_open;
	logic           is_reply;
	logic           open_slot;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.event_res = out_q.event_res;
	assign out_ch.trans_id_out = out_q.trans_id;
	assign out_ch.op_kind_out = out_q.op_kind;
	assign out_ch.last = out_last_q;

	assign is_open   = (func_q == FUNC_OPEN);
	assign is_reply  = (func_q == FUNC_REPLY);
	assign iss_done  = (iss_q == CW'(DEPTH));
	assign ent_valid = valid_q[d_idx_s1];
	assign id_hit    = d_vld_s1 && ent_valid && (mem_rdata.id == id_q);
	assign limit     = {1'b0, mem_rdata.tstamp} + {17'b0, cfg.expire_ticks};
	assign expired   = d_vld_s1 && ent_valid && (func_q == FUNC_TICK)
		&& (limit < {1'b0, now_q});
	assign out_busy  = out_v_q && !out_ch.ready;

	// A second expiry with an earlier one still queued needs the output
	// register; hold the scan and re-read the same entry until it frees up.
	assign stall     = expired && pend_v_q && out_busy;
	assign adv       = !stall;
	assign mem_raddr = adv ? iss_q[AW-1:0] : d_idx_s1;

	assign out_load = ((state_q == ST_SCAN) && adv && expired && pend_v_q)
		|| ((state_q == ST_FLUSH) && pend_v_q && !out_busy);
	assign out_load_last = (state_q == ST_FLUSH);

	assign new_rep    = (match_ent_q.replies == REPLIES_MAX) ? REPLIES_MAX
		: match_ent_q.replies + 2'd1;
	assign quorum_hit = (new_rep >= cfg.quorum_count);
	assign open_slot  = found_q || free_found_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = match_q;
		mem_wdata = '{id: id_q, op: op_kind_q, tstamp: now_q, replies: 2'd0};
		if (state_q == ST_FIN) begin
			if (is_open) begin
				mem_we    = open_slot;
				mem_waddr = found_q ? match_q : free_q;
			end else if (is_reply) begin
				mem_we    = found_q;
				mem_wdata = '{id: match_ent_q.id, op: match_ent_q.op,
					tstamp: match_ent_q.tstamp, replies: new_rep};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			iss_q        <= '0;
			d_vld_s1     <= 1'b0;
			valid_q      <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						iss_q        <= '0;
						d_vld_s1     <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						if (in_ch.func == FUNC_OPEN || in_ch.func == FUNC_REPLY
							|| in_ch.func == FUNC_TICK) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (adv) begin
						if (d_vld_s1) begin
							if (expired) begin
								valid_q[d_idx_s1] <= 1'b0;
								pend_v_q          <= 1'b1;
							end
							if (id_hit) begin
								found_q <= 1'b1;
							end
							if (!ent_valid) begin
								free_found_q <= 1'b1;
							end
						end
						if (!iss_done) begin
							d_vld_s1 <= 1'b1;
							iss_q    <= iss_q + CW'(1);
						end else begin
							d_vld_s1 <= 1'b0;
							if (!d_vld_s1) begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_FIN: begin
					if (is_open) begin
						if (open_slot) begin
							valid_q[mem_waddr] <= 1'b1;
						end else begin
							pend_v_q <= 1'b1;
						end
					end else if (is_reply && found_q && quorum_hit) begin
						valid_q[match_q] <= 1'b0;
						pend_v_q         <= 1'b1;
					end
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (!out_busy) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_q    <= in_ch.func;
			id_q      <= in_ch.trans_id;
			op_kind_q <= in_ch.op_kind;
			now_q     <= in_ch.now;
			ok_q      <= in_ch.reply_success;
		end
		if (state_q == ST_SCAN && adv) begin
			if (!iss_done) begin
				d_idx_s1 <= iss_q[AW-1:0];
			end
			// Only the first matching and the first free slot count.
			if (id_hit && !found_q) begin
				match_q     <= d_idx_s1;
				match_ent_q <= mem_rdata;
			end
			if (d_vld_s1 && !ent_valid && !free_found_q) begin
				free_q <= d_idx_s1;
			end
			if (expired) begin
				pend_q <= '{event_res: EV_EXPIRED, trans_id: mem_rdata.id,
					op_kind: mem_rdata.op};
			end
		end
		if (state_q == ST_FIN) begin
			if (is_open) begin
				pend_q <= '{event_res: EV_FULL, trans_id: id_q, op_kind: op_kind_q};
			end else if (is_reply) begin
				pend_q <= '{event_res: ok_q ? EV_SUCCESS : EV_FAILURE,
					trans_id: match_ent_q.id, op_kind: match_ent_q.op};
			end
		end
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= out_load_last;
		end
	end

	`QTT_ASSERT(a_idle_no_pend, clk, arst_n, !((state_q == ST_IDLE) && pend_v_q), "result left queued at idle")
	`QTT_ASSERT_IMPL(a_load_free, clk, arst_n, out_load, !out_busy, "output register overwritten while stalled")
	`QTT_ASSERT(a_stall_hold, clk, arst_n, stall |=> (d_vld_s1 && $stable(d_idx_s1)), "scan moved during a stall")
	`QTT_ASSERT_IMPL(a_iss_bound, clk, arst_n, state_q == ST_SCAN, iss_q <= CW'(DEPTH), "scan counter past table end")

endmodule

`default_nettype wire

[rtl/quorum_transaction_tracker_top.sv]
// ----------------------------------------------------------------------------
// Quorum transaction tracker
// Table of open replicated requests with quorum and expiry tracking.
// ----------------------------------------------------------------------------
// Usage:
// Requests come in on in_ch (open, reply, tick); results leave on out_ch,
// each carrying an event code, the transaction id and op kind, and last on
// the final result of its item. The APB port sets expire_ticks (0x0) and
// quorum_count (0x4); write it only while the block is idle.
// Every open, reply or tick item sweeps the whole entry memory, one entry per
// cycle through its single read port while out_ch does not stall, and in_ch
// is ready again after the update; an unused item kind causes no sweep and
// no result. Open and reply items give at most one result, after the sweep;
// it is valid on out_ch from the cycle in which in_ch is ready again.
// A tick gives one result per expired entry in ascending slot order; each one
// leaves when the next expired entry is found, and the last after the sweep.
// When out_ch stalls the sweep holds on the entry that needs the output, so
// the item takes longer, and nothing is lost. The output register lets the
// next item be accepted while the last result still waits.
// Reset clears the per-entry valid flags and the registers to their defaults
// at once; no clearing pass runs over the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module quorum_transaction_tracker_top
	import qtt_pkg::*;
#(
	parameter int TABLE_DEPTH = QTT_TABLE_DEPTH
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	qtt_in_if.sink           in_ch,
	qtt_out_if.source        out_ch
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	cfg_t          cfg;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	qtt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qtt_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	qtt_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

`default_nettype wire

[bench/quorum_transaction_tracker_top_tb.sv]
// ----------------------------------------------------------------------------
// Quorum transaction tracker testbench
// Sends open, reply and tick items, with noise, into the tracker. It predicts
// the events that each accepted item causes and compares every result, field
// by field, in order. Both channels stall at random. The expiry and quorum
// registers are rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quorum_transaction_tracker_top_tb;
	import qtt_pkg::*;

	localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
	localparam logic [30:0] ID_TOP        = 31'h7FFF_FFFE;
	localparam int          PHASES        = 6;
	localparam int          PHASE_ITEMS   = 28;
	localparam int          POOL_SIZE     = 24;
	localparam int          SETTLE_CYCLES = QTT_TABLE_DEPTH + 16;
	localparam int          LIMIT_CYCLES  = 400000;

	typedef struct packed {
		logic [1:0]  func;
		logic [30:0] trans_id;
		logic [1:0]  op_kind;
		logic [31:0] now;
		logic        reply_success;
	} request_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [30:0] trans_id;
		logic [1:0]  op_kind;
		logic        last;
	} outcome_t;

	class quorum_scoreboard;
		logic        slot_busy[QTT_TABLE_DEPTH];
		logic [30:0] slot_id[QTT_TABLE_DEPTH];
		logic [1:0]  slot_op[QTT_TABLE_DEPTH];
		logic [31:0] slot_time[QTT_TABLE_DEPTH];
		logic [1:0]  slot_replies[QTT_TABLE_DEPTH];
		logic [15:0] expire_ticks;
		logic [1:0]  quorum_count;
		outcome_t    events_due[$];
		int          mismatches;
		int          by_event[4];

		function new();
			foreach (slot_busy[i])
				slot_busy[i] = 1'b0;
			foreach (by_event[i])
				by_event[i] = 0;
			expire_ticks = EXPIRE_RESET;
			quorum_count = QUORUM_RESET;
			mismatches = 0;
		endfunction

		function void set_register(logic idx, logic [31:0] value);
			if (idx == REG_EXPIRE) begin
				expire_ticks = value[15:0];
			end else begin
				quorum_count = value[1:0];
			end
		endfunction

		function int lookup(logic [30:0] id);
			for (int i = 0; i < QTT_TABLE_DEPTH; i++)
				if (slot_busy[i] && slot_id[i] == id)
					return i;
			return -1;
		endfunction

		function void note_input(request_t req);
			outcome_t    batch[$];
			int          slot;
			logic [32:0] deadline;
			case (req.func)
			FUNC_OPEN: begin
				slot = lookup(req.trans_id);
				for (int i = 0; i < QTT_TABLE_DEPTH && slot < 0; i++)
					if (!slot_busy[i])
						slot = i;
				if (slot < 0) begin
					batch.push_back('{EV_FULL, req.trans_id, req.op_kind, 1'b0});
				end else begin
					slot_busy[slot] = 1'b1;
					slot_id[slot] = req.trans_id;
					slot_op[slot] = req.op_kind;
					slot_time[slot] = req.now;
					slot_replies[slot] = 2'd0;
				end
			end
			FUNC_REPLY: begin
				slot = lookup(req.trans_id);
				if (slot >= 0) begin
					if (slot_replies[slot] < REPLIES_MAX)
						slot_replies[slot] = slot_replies[slot] + 2'd1;
					if (slot_replies[slot] >= quorum_count) begin
						slot_busy[slot] = 1'b0;
						batch.push_back('{req.reply_success ? EV_SUCCESS : EV_FAILURE,
							slot_id[slot], slot_op[slot], 1'b0});
					end
				end
			end
			FUNC_TICK: begin
				for (int i = 0; i < QTT_TABLE_DEPTH; i++) begin
					// The deadline is one bit wider so it cannot wrap.
					deadline = {1'b0, slot_time[i]} + {17'd0, expire_ticks};
					if (slot_busy[i] && deadline < {1'b0, req.now}) begin
						slot_busy[i] = 1'b0;
						batch.push_back('{EV_EXPIRED, slot_id[i], slot_op[i], 1'b0});
					end
				end
			end
			default: begin
			end
			endcase
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[k])
				events_due.push_back(batch[k]);
		endfunction

		function void complain(string msg);
			if (mismatches < 10)
				$display("%0t: %s", $realtime, msg);
			mismatches++;
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (events_due.size() == 0) begin
				complain($sformatf("unexpected result ev %0d id %h op %0d last %0b",
					got.event_res, got.trans_id, got.op_kind, got.last));
				return;
			end
			want = events_due.pop_front();
			by_event[want.event_res]++;
			if (got.event_res !== want.event_res || got.trans_id !== want.trans_id ||
				got.op_kind !== want.op_kind || got.last !== want.last) begin
				complain($sformatf({"result mismatch: expected ev %0d id %h op %0d last %0b,",
					" got ev %0d id %h op %0d last %0b"},
					want.event_res, want.trans_id, want.op_kind, want.last,
					got.event_res, got.trans_id, got.op_kind, got.last));
			end
		endfunction

		function int pending();
			return events_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	qtt_in_if  in_ch ();
	qtt_out_if out_ch ();

	quorum_transaction_tracker_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	quorum_scoreboard sb = new();
	int          sender_idle_pct = 20;
	int          receiver_stall_pct = 72;
	int          items_sent = 0;
	int          cycle_count = 0;
	logic [31:0] clock_now;
	logic [30:0] id_pool[POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles, %0d results outstanding.",
			cycle_count, sb.pending());
		$display("FAIL");
		$finish;
	end

	// Result side: check what was taken at this edge, then pick the next ready.
	initial begin
		outcome_t seen;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				seen = '{out_ch.event_res, out_ch.trans_id_out, out_ch.op_kind_out, out_ch.last};
				sb.check_result(seen);
			end
			out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	function automatic request_t make_request(logic [1:0] func, logic [30:0] id,
		logic [1:0] op, logic [31:0] now, logic ok);
		request_t r;
		r = '{func, id, op, now, ok};
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       pick;
		pick = $urandom_range(99);
		clock_now = clock_now + $urandom_range(3);
		r.func = FUNC_OPEN;
		r.trans_id = id_pool[$urandom_range(POOL_SIZE - 1)];
		r.op_kind = 2'($urandom_range(3));
		r.now = clock_now;
		r.reply_success = 1'($urandom_range(1));
		if (pick < 40) begin
			r.func = FUNC_OPEN;
		end else if (pick < 75) begin
			r.func = FUNC_REPLY;
			r.now = $urandom();
			if ($urandom_range(9) == 0)
				r.trans_id = 31'($urandom_range(ID_TOP));
		end else if (pick < 92) begin
			r.func = FUNC_TICK;
		end else if (pick < 96) begin
			// A tick at a random time, which may lie far from the running time.
			r.func = FUNC_TICK;
			r.now = $urandom();
		end else begin
			r.func = FUNC_UNUSED;
			r.trans_id = 31'($urandom_range(ID_TOP));
			r.now = $urandom();
		end
		return r;
	endfunction

	task automatic send_item(request_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= r.func;
		in_ch.trans_id <= r.trans_id;
		in_ch.op_kind <= r.op_kind;
		in_ch.now <= r.now;
		in_ch.reply_success <= r.reply_success;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_input(r);
		items_sent++;
	endtask

	// Called in the step of the last accept, so valid falls only once there.
	task automatic await_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	// Opens and replies may give no result, so let a full sweep pass as well.
	task automatic await_quiet();
		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] expire_plan[PHASES];
		logic [1:0]  quorum_plan[PHASES];
		request_t    r;
		int          accepted;
		int          settings_used;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.func <= FUNC_OPEN;
		in_ch.trans_id <= '0;
		in_ch.op_kind <= '0;
		in_ch.now <= '0;
		in_ch.reply_success <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset settings (expiry 8, quorum 2).
		settings_used = 1;
		send_item(make_request(FUNC_UNUSED, ID_TOP, 2'd3, '1, 1'b1));
		send_item(make_request(FUNC_OPEN, ID_TOP, 2'd3, 32'hFFFF_FFFF, 1'b0));
		send_item(make_request(FUNC_OPEN, 31'd5, 2'd1, 32'd100, 1'b0));
		send_item(make_request(FUNC_OPEN, 31'd5, 2'd2, 32'd200, 1'b0));
		send_item(make_request(FUNC_REPLY, 31'd0, 2'd0, 32'd0, 1'b1));
		send_item(make_request(FUNC_REPLY, 31'd5, 2'd0, 32'd0, 1'b1));
		send_item(make_request(FUNC_REPLY, 31'd5, 2'd0, 32'd0, 1'b0));
		// Fill the table next to the top id, then open one more.
		for (int i = 0; i < QTT_TABLE_DEPTH - 1; i++)
			send_item(make_request(FUNC_OPEN, 31'(i), 2'(i), 32'(10 + i), 1'b0));
		send_item(make_request(FUNC_OPEN, 31'd999, 2'd1, 32'd300, 1'b0));
		// All but the entry opened at the top of time expire, in slot order.
		send_item(make_request(FUNC_TICK, 31'd0, 2'd0, 32'd1000, 1'b0));

		await_quiet();
		write_register(REG_QUORUM, 32'd0);
		settings_used++;
		send_item(make_request(FUNC_REPLY, ID_TOP, 2'd0, 32'd0, 1'b1));
		await_quiet();
		write_register(REG_EXPIRE, 32'd0);
		settings_used++;
		send_item(make_request(FUNC_OPEN, 31'h2AAA_AAAA, 2'd1, 32'd50, 1'b0));
		send_item(make_request(FUNC_TICK, 31'd0, 2'd0, 32'd50, 1'b0));
		send_item(make_request(FUNC_TICK, 31'd0, 2'd0, 32'd51, 1'b0));

		expire_plan = '{16'hFFFF, 16'd0, 16'd20, 16'd6, 16'($urandom_range(64, 1)),
			16'($urandom())};
		quorum_plan = '{2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'($urandom_range(3, 1))};
		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
			0: begin
				sender_idle_pct = 20;
				receiver_stall_pct = 72;
			end
			1: begin
				sender_idle_pct = 72;
				receiver_stall_pct = 20;
			end
			default: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			endcase
			await_quiet();
			write_register(REG_EXPIRE, {16'd0, expire_plan[p]});
			write_register(REG_QUORUM, {30'd0, quorum_plan[p]});
			settings_used++;
			foreach (id_pool[i])
				id_pool[i] = 31'($urandom_range(ID_TOP));
			clock_now = $urandom();
			accepted = 0;
			while (accepted < PHASE_ITEMS) begin
				r = random_request();
				send_item(r);
				if (r.func != FUNC_UNUSED) begin
					accepted++;
					if (accepted == PHASE_ITEMS / 2)
						await_results();
				end
			end
		end

		await_quiet();
		$display("Sent %0d items under %0d register settings, full table and zero quorum included.",
			items_sent, settings_used);
		$display("Checked results: %0d success, %0d failure, %0d expired, %0d table full.",
			sb.by_event[EV_SUCCESS], sb.by_event[EV_FAILURE], sb.by_event[EV_EXPIRED],
			sb.by_event[EV_FULL]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results never seen.", sb.mismatches, sb.pending());
			$display("FAIL");
		end
		$finish;
	end

endmodule

[quorum_transaction_tracker_top.f]
+incdir+rtl
rtl/qtt_pkg.sv
rtl/qtt_if.sv
rtl/qtt_cfg.sv
rtl/qtt_mem.sv
rtl/qtt_ctrl.sv
rtl/quorum_transaction_tracker_top.sv
bench/quorum_transaction_tracker_top_tb.sv
